// ===== rtl/pexp_pkg.sv =====
// ----------------------------------------------------------------------------
// pexp_pkg
// Shared types, codes and the pixel packing function of the palette
// expander.
// ----------------------------------------------------------------------------
package pexp_pkg;

    // item kind carried on the input tuser
    typedef enum logic {
        CMD_PAL_WRITE = 1'b0,
        CMD_DATA      = 1'b1
    } t_cmd;

    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned COLOR_W     = 24;
    localparam int unsigned CFG_W       = 3;
    localparam int unsigned CFG_IDX_W   = 1;

    typedef logic [CFG_W-1:0]     t_src_fmt;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [COLOR_W-1:0]   t_color;
    typedef logic [OUT_TDATA_W-1:0] t_pixel;

    // configuration register indexes
    localparam t_cfg_idx CFG_SOURCE_FORMAT = 1'b0;
    localparam t_cfg_idx CFG_OUTPUT_FORMAT = 1'b1;

    // source formats
    localparam t_src_fmt SRC_1BPP   = 3'd0;
    localparam t_src_fmt SRC_2BPP   = 3'd1;
    localparam t_src_fmt SRC_4BPP   = 3'd2;
    localparam t_src_fmt SRC_8BPP   = 3'd3;
    localparam t_src_fmt SRC_DIRECT = 3'd4;

    // output formats
    localparam logic OUT_RGB565 = 1'b0;
    localparam logic OUT_BGR555 = 1'b1;

    // colour has red in 7:0, green in 15:8, blue in 23:16
    function automatic t_pixel pack_pixel(input t_color col, input logic out_fmt);
        t_pixel res;
        if (out_fmt == OUT_RGB565) begin
            res = {col[7:3], col[15:10], col[23:19]};
        end else begin
            res = {1'b0, col[23:19], col[15:11], col[7:3]};
        end
        return res;
    endfunction

endpackage

// ===== rtl/palette_expand_to_rgb16.sv =====
// ----------------------------------------------------------------------------
// palette_expand_to_rgb16
// Palette lookup and RGB565 / BGR555 packing of indexed or direct pixels.
// ----------------------------------------------------------------------------
// The block puts out one 16-bit pixel per cycle while the output is not
// stalled. An input item is held in the unpack register until all its pixels
// have gone to the palette read port: 8 for a 1bpp byte, 4 for 2bpp, 2 for
// 4bpp, 1 for an 8bpp byte or a direct colour word, and none for a palette
// write or an item in an undefined format. The single palette read port, one
// pixel per cycle, sets that rate. A pixel passes the unpack register, palette
// read register and output register. Palette writes are applied in item order,
// so a write followed by data that uses the entry sees the new colour.
// ----------------------------------------------------------------------------
module palette_expand_to_rgb16 #(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  pexp_pkg::t_cfg_idx                  i_cfg_index,
    input  logic [pexp_pkg::CFG_W-1:0]          i_cfg_wdata,
    // input stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // pal_index [7:0], pal_color [31:8], data [63:32]
    input  logic [pexp_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // cmd [0]
    input  pexp_pkg::t_cmd                      i_s_tuser,
    // output stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // pixel [15:0]
    output logic [pexp_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // last
    output logic                                o_m_tlast
);
    import pexp_pkg::*;

    localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0]  ENTRIES_W = 9'(PALETTE_ENTRIES);

    // configuration
    t_src_fmt r_src_fmt;
    logic     r_out_fmt;

    // unpack stage
    logic       r_s1_valid;
    t_cmd       r_s1_cmd;
    logic [7:0] r_s1_idx;
    t_color     r_s1_col;
    logic [2:0] r_s1_k;

    // lookup stage
    logic   r_s2_valid;
    logic   r_s2_direct;
    logic   r_s2_zero;
    logic   r_s2_last;
    t_color r_s2_col;
    t_color rd_data;

    // output stage
    logic   r_o_valid;
    t_pixel r_o_data;
    logic   r_o_last;

    logic       s1_produces;
    logic       s1_adv;
    logic       s1_done;
    logic       s2_ready;
    logic       s2_load;
    logic       s3_ready;
    logic       s3_load;
    logic       in_accept;
    logic       pix_last;
    logic [7:0] pix;
    logic [7:0] shifted;
    logic       wr_en;
    t_color     s3_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= SRC_8BPP;
            r_out_fmt <= OUT_RGB565;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_SOURCE_FORMAT) begin
                r_src_fmt <= i_cfg_wdata;
            end else begin
                r_out_fmt <= i_cfg_wdata[0];
            end
        end
    end

    // pixel index and last flag for the current position within the byte
    always_comb begin
        shifted  = 8'd0;
        pix      = 8'd0;
        pix_last = 1'b1;
        unique case (r_src_fmt)
            SRC_1BPP: begin
                shifted  = r_s1_col[7:0] >> r_s1_k;
                pix      = {7'd0, shifted[0]};
                pix_last = (r_s1_k == 3'd7);
            end
            SRC_2BPP: begin
                shifted  = r_s1_col[7:0] >> {r_s1_k[1:0], 1'b0};
                pix      = {6'd0, shifted[1:0]};
                pix_last = (r_s1_k[1:0] == 2'd3);
            end
            SRC_4BPP: begin
                shifted  = r_s1_col[7:0] >> {r_s1_k[0], 2'b00};
                pix      = {4'd0, shifted[3:0]};
                pix_last = r_s1_k[0];
            end
            SRC_8BPP: begin
                pix      = r_s1_col[7:0];
            end
            default: begin
                pix      = 8'd0;
            end
        endcase
    end

    always_comb begin
        s1_produces = (r_s1_cmd == CMD_DATA) && (r_src_fmt <= SRC_DIRECT);
        s3_ready    = !r_o_valid || i_m_tready;
        s2_ready    = !r_s2_valid || s3_ready;
        s1_adv      = r_s1_valid && (!s1_produces || s2_ready);
        s1_done     = s1_adv && (!s1_produces || pix_last);
        s2_load     = s1_adv && s1_produces;
        s3_load     = r_s2_valid && s3_ready;
        in_accept   = i_s_tvalid && o_s_tready;
        wr_en       = s1_adv && (r_s1_cmd == CMD_PAL_WRITE)
                      && ({1'b0, r_s1_idx} < ENTRIES_W);
    end

    assign o_s_tready = !r_s1_valid || s1_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_done) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd <= i_s_tuser;
            r_s1_idx <= i_s_tdata[7:0];
            r_s1_k   <= 3'd0;
            // palette writes keep the colour, data items the low data bits
            if (i_s_tuser == CMD_PAL_WRITE) begin
                r_s1_col <= i_s_tdata[31:8];
            end else begin
                r_s1_col <= i_s_tdata[55:32];
            end
        end else if (s1_adv) begin
            r_s1_k <= r_s1_k + 3'd1;
        end
    end

    pexp_palette_ram #(
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_idx[AW-1:0]),
        .i_wr_data (r_s1_col),
        .i_rd_en   (s2_load),
        .i_rd_addr (pix[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_load) begin
            r_s2_valid <= 1'b1;
        end else if (s3_load) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_direct <= (r_src_fmt == SRC_DIRECT);
            r_s2_zero   <= ({1'b0, pix} >= ENTRIES_W);
            r_s2_last   <= pix_last;
            r_s2_col    <= r_s1_col;
        end
    end

    always_comb begin
        if (r_s2_direct) begin
            s3_col = r_s2_col;
        end else if (r_s2_zero) begin
            s3_col = '0;
        end else begin
            s3_col = rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s3_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s3_load) begin
            r_o_data <= pack_pixel(s3_col, r_out_fmt);
            r_o_last <= r_s2_last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tlast  = r_o_last;

endmodule

// ===== rtl/pexp_palette_ram.sv =====
// ----------------------------------------------------------------------------
// pexp_palette_ram
// Colour palette store: one write port, one read port with registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module pexp_palette_ram #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  pexp_pkg::t_color         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output pexp_pkg::t_color         o_rd_data
);
    import pexp_pkg::*;

    t_color r_mem [DEPTH];
    t_color r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/pexp_checker.sv =====
// ----------------------------------------------------------------------------
// pexp_checker
// Port-level checks of the palette expander, bound to the top level.
// ----------------------------------------------------------------------------
module pexp_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             o_s_tready,
    input  pexp_pkg::t_cmd                   i_s_tuser,
    input  logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [pexp_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                             o_m_tlast
);
    import pexp_pkg::*;

    // set once any data item has been taken
    logic r_seen_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_data <= 1'b0;
        end else if (i_s_tvalid && o_s_tready && (i_s_tuser == CMD_DATA)) begin
            r_seen_data <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid straight after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output item changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_seen_data)
        else $error("pixel produced before any data item");

endmodule

bind palette_expand_to_rgb16 pexp_checker u_pexp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the palette expander. The palette is loaded first.
// Then short directed items go through every source and output format, the
// undefined formats among them. Random traffic then runs under changing
// settings and changing sender and receiver back-pressure. Each pixel is
// compared with a shadow palette and packer that the testbench keeps itself.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pexp_pkg::*;

    localparam int unsigned CLUT_DEPTH     = 256;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned MAX_PRINTS     = 40;

    typedef struct packed {
        t_pixel pixel;
        logic   last;
    } t_pixel_item;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    t_cfg_idx               i_cfg_index = CFG_SOURCE_FORMAT;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    t_cmd                   i_s_tuser   = CMD_PAL_WRITE;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    // shadow state of the block
    t_color      clut_shadow [CLUT_DEPTH];
    t_src_fmt    src_fmt = SRC_8BPP;
    logic        out_fmt = OUT_RGB565;
    t_pixel_item pending_pixels [$];

    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    palette_expand_to_rgb16 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // colour has red in 7:0, green in 15:8, blue in 23:16
    function automatic t_pixel packed_colour(input t_color col);
        logic [15:0] red, grn, blu;
        red = {8'd0, col[7:0]};
        grn = {8'd0, col[15:8]};
        blu = {8'd0, col[23:16]};
        if (out_fmt == OUT_RGB565) begin
            return ((red >> 3) << 11) | ((grn >> 2) << 5) | (blu >> 3);
        end
        return ((blu >> 3) << 10) | ((grn >> 3) << 5) | (red >> 3);
    endfunction

    function automatic void expand_item(input t_cmd cmd, input logic [7:0] idx,
                                        input t_color col, input logic [31:0] word);
        int unsigned bpp, count, k;
        logic [7:0]  code;
        if (cmd == CMD_PAL_WRITE) begin
            clut_shadow[idx] = col;
            return;
        end
        if (src_fmt == SRC_DIRECT) begin
            // alpha byte dropped
            pending_pixels.push_back('{packed_colour(word[23:0]), 1'b1});
        end else if (src_fmt <= SRC_8BPP) begin
            bpp   = 1 << src_fmt;
            count = 8 / bpp;
            for (k = 0; k < count; k++) begin
                code = 8'((word[7:0] >> (k * bpp)) & ((1 << bpp) - 1));
                pending_pixels.push_back('{packed_colour(clut_shadow[code]),
                                           k + 1 == count});
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : check_pixels
        t_pixel_item want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %h arrived with none pending", o_m_tdata));
            end else begin
                want = pending_pixels.pop_front();
                if (o_m_tdata !== want.pixel) begin
                    report_mismatch($sformatf("pixel %h, wanted %h", o_m_tdata, want.pixel));
                end
                if (o_m_tlast !== want.last) begin
                    report_mismatch($sformatf("tlast %b, wanted %b", o_m_tlast, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // valid stays high between back-to-back items and drops only for a gap
    task automatic push_item(input t_cmd cmd, input logic [7:0] idx,
                             input t_color col, input logic [31:0] word);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {word, col, idx};
        do @(posedge i_clk); while (!o_s_tready);
        expand_item(cmd, idx, col, word);
    endtask

    task automatic drain_pipeline();
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_SOURCE_FORMAT) begin
            src_fmt = val;
        end else begin
            out_fmt = val[0];
        end
        @(posedge i_clk);
    endtask

    // every entry gets written so that no lookup ever hits an unwritten one
    task automatic test_palette_load();
        for (int i = 0; i < CLUT_DEPTH; i++) begin
            push_item(CMD_PAL_WRITE, 8'(i), t_color'($urandom), $urandom);
        end
    endtask

    task automatic test_directed_formats();
        logic [31:0] samples [5][2] = '{
            '{32'hFFFF_FFA5, 32'h0000_0000},
            '{32'h0000_001B, 32'hFFFF_FFE4},
            '{32'h1234_56F0, 32'h0000_000F},
            '{32'h0000_00FF, 32'hFFFF_FF00},
            '{32'hFFFF_FFFF, 32'h00F8_FC07}
        };
        logic ofmt;
        push_item(CMD_PAL_WRITE, 8'h00, 24'h000000, 32'hFFFF_FFFF);
        push_item(CMD_PAL_WRITE, 8'hFF, 24'hFFFFFF, 32'h0000_0000);
        for (int o = 0; o < 2; o++) begin
            ofmt = (o == 0) ? OUT_RGB565 : OUT_BGR555;
            drain_pipeline();
            cfg_write(CFG_OUTPUT_FORMAT, CFG_W'(ofmt));
            for (int fmt = SRC_1BPP; fmt <= SRC_DIRECT; fmt++) begin
                drain_pipeline();
                cfg_write(CFG_SOURCE_FORMAT, CFG_W'(fmt));
                for (int s = 0; s < 2; s++) begin
                    push_item(CMD_DATA, 8'($urandom), t_color'($urandom), samples[fmt][s]);
                end
            end
        end
        // undefined source formats give nothing
        for (int fmt = SRC_DIRECT + 1; fmt < (1 << CFG_W); fmt++) begin
            drain_pipeline();
            cfg_write(CFG_SOURCE_FORMAT, CFG_W'(fmt));
            push_item(CMD_DATA, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF);
        end
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle,
                                       input int unsigned stall);
        t_src_fmt    fmt;
        logic [7:0]  idx;
        int unsigned sent;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < n_items) begin
            drain_pipeline();
            if ($urandom_range(9) < 8) begin
                fmt = t_src_fmt'($urandom_range(SRC_DIRECT, SRC_1BPP));
            end else begin
                fmt = t_src_fmt'($urandom_range((1 << CFG_W) - 1, SRC_DIRECT + 1));
            end
            cfg_write(CFG_SOURCE_FORMAT, fmt);
            cfg_write(CFG_OUTPUT_FORMAT, CFG_W'($urandom));
            for (int i = 0; i < 25 && sent < n_items; i++) begin
                if ($urandom_range(4) == 0) begin
                    // low entries are the ones the narrow formats reach
                    idx = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(15));
                    push_item(CMD_PAL_WRITE, idx, t_color'($urandom), $urandom);
                end else begin
                    push_item(CMD_DATA, 8'($urandom), t_color'($urandom), $urandom);
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_palette_load();
        test_directed_formats();
        test_random_traffic(30, 0, 0);
        test_random_traffic(30, 88, 0);
        test_random_traffic(30, 0, 88);
        test_random_traffic(30, 19, 19);

        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
